>>> rtl/quadrature_position_speed_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef QUADRATURE_POSITION_SPEED_MACROS_SVH
`define QUADRATURE_POSITION_SPEED_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define QPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define QPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define QPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/qps_pkg.sv
`timescale 1ns / 1ps
package qps_pkg;

    localparam logic [15:0] CPR_RESET = 16'd1320;
    // 2*pi*1000*2^16, truncated
    localparam logic [28:0] SPEED_K   = 29'd411774832;

    localparam int NUM_W   = 61;
    localparam int DEN_W   = 48;
    localparam int QBITS   = 31;
    localparam int STEP_W  = 5;

    localparam logic [1:0] ACT_EDGE_A = 2'd0;
    localparam logic [1:0] ACT_EDGE_B = 2'd1;
    localparam logic [1:0] ACT_SPEED  = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic CPR_INDEX = 1'b0;

    typedef struct packed {
        logic load;
        logic mul;
        logic prep;
        logic step;
        logic out_load;
    } qps_cmd_t;

    typedef struct packed {
        logic is_speed;
        logic dt_zero;
    } qps_stat_t;

endpackage

>>> rtl/quadrature_position_speed.sv
`timescale 1ns / 1ps
// Quadrature x4 position counter with speed estimate.
// Input stream: s_tuser carries the event kind (edge on A, edge on B, speed
// request, clear); s_tdata carries the channel levels and a millisecond stamp.
// Output stream: one transfer per input event with the position after the
// event and, on a speed request, the speed in rad/s as signed Q15.16.
// APB: counts_per_rev at byte address 0; the user must write it only while
// the block is idle; the block itself does not enforce this.
// Sequence: an edge or clear event passes through MUL without arithmetic and
// loads the output in DONE; a speed request runs the multiply (MUL), rounding
// and saturation (PREP), the one-bit-per-cycle restoring divider (DIV) and
// the output load (DONE), and m_tvalid rises after the load.
// A speed request with zero elapsed time skips the multiply, rounding and
// divider. One event is in work at a time; s_tready is high only when the
// sequencer is idle and returns the cycle after the result loads.
// The output register holds a finished result while m_tready is low and the
// next event is still accepted; its result waits in the datapath until then.
// Reset clears position, the stored speed reference and counts_per_rev
// returns to 1320.
module quadrature_position_speed
    import qps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // level_a, level_b, now_ms[31:0], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // position[31:0], speed[31:0]
    output logic [1:0]  m_tuser,   // speed_valid, zero_interval
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] cpr_reg;
    logic [15:0] cpr_eff;
    qps_cmd_t    cmd;
    qps_stat_t   stat;
    logic [31:0] position, speed;
    logic        speed_valid, zero_interval;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CPR_INDEX) ? {16'd0, cpr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg <= CPR_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == CPR_INDEX))
        begin
            cpr_reg <= pwdata[15:0];
        end
    end

    // a zero setting scales as one
    assign cpr_eff = (cpr_reg == '0) ? 16'd1 : cpr_reg;

    qps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    qps_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cpr           (cpr_eff),
        .action        (s_tuser),
        .level_a       (s_tdata[0]),
        .level_b       (s_tdata[1]),
        .now_ms        (s_tdata[33:2]),
        .position      (position),
        .speed         (speed),
        .speed_valid   (speed_valid),
        .zero_interval (zero_interval)
    );

    assign m_tdata = {speed, position};
    assign m_tuser = {zero_interval, speed_valid};

endmodule

>>> rtl/qps_ctrl.sv
`timescale 1ns / 1ps
`include "quadrature_position_speed_macros.svh"
module qps_ctrl
    import qps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  qps_stat_t stat,
    output qps_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QBITS - 1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              can_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign can_load  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // edges, clears and zero intervals need no arithmetic
                if (!stat.is_speed || stat.dt_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = STEP_LAST;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (can_load)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `QPS_ASSERT_NEXT(a_div_ends, clk, rst_n, (state_reg == ST_DIV) && (step_reg == '0), state_reg == ST_DONE)
    `QPS_ASSERT_NEXT(a_done_holds, clk, rst_n, (state_reg == ST_DONE) && !can_load, (state_reg == ST_DONE) && out_valid_reg)
    `QPS_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid_reg && (state_reg == ST_IDLE))

endmodule

>>> rtl/qps_dp.sv
`timescale 1ns / 1ps
`include "quadrature_position_speed_macros.svh"
module qps_dp
    import qps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  qps_cmd_t    cmd,
    output qps_stat_t   stat,
    input  logic [15:0] cpr,
    input  logic [1:0]  action,
    input  logic        level_a,
    input  logic        level_b,
    input  logic [31:0] now_ms,
    output logic [31:0] position,
    output logic [31:0] speed,
    output logic        speed_valid,
    output logic        zero_interval
);

    logic [31:0]      count_reg, cals_reg, tals_reg;
    logic [1:0]       act_reg;
    logic             neg_reg;
    logic [31:0]      mag_reg;
    logic [31:0]      dt_reg;
    logic             dt_zero_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic             sat_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [QBITS-1:0] low_reg;
    logic [QBITS-1:0] quot_reg;
    logic [31:0]      position_reg, speed_reg;
    logic             speed_valid_reg, zero_reg;

    logic [31:0]          dc;
    logic [31:0]          dt;
    logic [NUM_W-1:0]     rounded;
    logic [DEN_W+QBITS:0] den_top;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_diff;
    logic                 qbit;
    logic [31:0]          quot_ext;
    logic [31:0]          speed_val;

    assign dc = count_reg - cals_reg;
    assign dt = now_ms - tals_reg;

    // rounding offset and saturation bound for the quotient
    assign rounded = num_reg + NUM_W'(den_reg >> 1);
    assign den_top = {1'b0, den_reg, {QBITS{1'b0}}};

    assign rem_sh   = {rem_reg, low_reg[QBITS-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign qbit     = (rem_sh >= {1'b0, den_reg});

    assign quot_ext = {1'b0, quot_reg};

    always_comb
    begin
        speed_val = '0;
        if ((act_reg == ACT_SPEED) && !dt_zero_reg)
        begin
            if (sat_reg)
            begin
                speed_val = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                speed_val = neg_reg ? (~quot_ext + 32'd1) : quot_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cals_reg  <= '0;
            tals_reg  <= '0;
        end
        else if (cmd.load)
        begin
            case (action)
                ACT_EDGE_A:
                begin
                    count_reg <= (level_a == level_b) ? count_reg + 32'd1 : count_reg - 32'd1;
                end
                ACT_EDGE_B:
                begin
                    count_reg <= (level_a != level_b) ? count_reg + 32'd1 : count_reg - 32'd1;
                end
                ACT_SPEED:
                begin
                    cals_reg <= count_reg;
                    tals_reg <= now_ms;
                end
                default:
                begin
                    count_reg <= '0;
                    cals_reg  <= '0;
                    tals_reg  <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= action;
            neg_reg     <= dc[31];
            mag_reg     <= dc[31] ? (~dc + 32'd1) : dc;
            dt_reg      <= dt;
            dt_zero_reg <= (dt == '0);
        end
        if (cmd.mul)
        begin
            num_reg <= NUM_W'(mag_reg) * NUM_W'(SPEED_K);
            den_reg <= DEN_W'(dt_reg) * DEN_W'(cpr);
        end
        if (cmd.prep)
        begin
            sat_reg  <= ({{(DEN_W + QBITS + 1 - NUM_W){1'b0}}, rounded} >= den_top);
            rem_reg  <= DEN_W'(rounded[NUM_W-1:QBITS]);
            low_reg  <= rounded[QBITS-1:0];
            quot_reg <= '0;
        end
        if (cmd.step)
        begin
            rem_reg  <= qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            low_reg  <= {low_reg[QBITS-2:0], 1'b0};
            quot_reg <= {quot_reg[QBITS-2:0], qbit};
        end
        if (cmd.out_load)
        begin
            position_reg    <= count_reg;
            speed_reg       <= speed_val;
            speed_valid_reg <= (act_reg == ACT_SPEED);
            zero_reg        <= (act_reg == ACT_SPEED) && dt_zero_reg;
        end
    end

    assign stat.is_speed = (act_reg == ACT_SPEED);
    assign stat.dt_zero  = dt_zero_reg;

    assign position      = position_reg;
    assign speed         = speed_reg;
    assign speed_valid   = speed_valid_reg;
    assign zero_interval = zero_reg;

    `QPS_ASSERT_NEXT(a_zero_speed, clk, rst_n, cmd.out_load && (act_reg == ACT_SPEED) && dt_zero_reg, (speed_reg == '0) && speed_valid_reg && zero_reg)
    `QPS_ASSERT_NEXT(a_clear_pos, clk, rst_n, cmd.load && (action == ACT_CLEAR), (count_reg == '0) && (cals_reg == '0) && (tals_reg == '0))

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb
    import qps_pkg::*;
();

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] speed;
        logic        speed_valid;
        logic        zero_interval;
    } qps_result_t;

    // 2*pi*1000 in Q16, truncated
    localparam longint unsigned RAD_SCALE = 64'd411774832;
    localparam logic [2:0]      CPR_ADDR  = {CPR_INDEX, 2'b00};

    class qps_board;
        int unsigned errors;
        logic [31:0] count;
        logic [31:0] count_ref;
        logic [31:0] time_ref;
        logic [15:0] cpr;
        qps_result_t expected_q[$];

        function new();
            errors = 0;
            count = '0;
            count_ref = '0;
            time_ref = '0;
            cpr = CPR_RESET;
        endfunction

        function void set_cpr(logic [15:0] value);
            cpr = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] rad_per_sec(logic [31:0] dcount, logic [31:0] dms);
            logic neg;
            logic [31:0] neg_count;
            longint unsigned mag;
            longint unsigned den;
            longint unsigned q;
            neg = dcount[31];
            neg_count = -dcount;
            mag = neg ? {32'd0, neg_count} : {32'd0, dcount};
            den = {32'd0, dms} * ((cpr == 16'd0) ? 64'd1 : {48'd0, cpr});
            // round half away from zero on the magnitude, sign goes on after
            q = (mag * RAD_SCALE + den / 2) / den;
            if (neg)
                return (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
            return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        endfunction

        function void note_event(logic [1:0] act, logic la, logic lb, logic [31:0] now);
            qps_result_t r;
            r = '0;
            case (act)
                ACT_EDGE_A: count = (la == lb) ? count + 1 : count - 1;
                ACT_EDGE_B: count = (la != lb) ? count + 1 : count - 1;
                ACT_SPEED:
                begin
                    r.speed_valid = 1'b1;
                    if (now == time_ref)
                        r.zero_interval = 1'b1;
                    else
                        r.speed = rad_per_sec(count - count_ref, now - time_ref);
                    count_ref = count;
                    time_ref = now;
                end
                default:
                begin
                    count = '0;
                    count_ref = '0;
                    time_ref = '0;
                end
            endcase
            r.position = count;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] pos, logic [31:0] spd, logic sv, logic zi);
            qps_result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, position %h speed %h",
                         $time, pos, spd);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (pos !== e.position)
            begin
                $display("%0t: position expected %h actual %h", $time, e.position, pos);
                errors++;
            end
            if (spd !== e.speed)
            begin
                $display("%0t: speed expected %h actual %h", $time, e.speed, spd);
                errors++;
            end
            if (sv !== e.speed_valid)
            begin
                $display("%0t: speed_valid expected %b actual %b", $time, e.speed_valid, sv);
                errors++;
            end
            if (zi !== e.zero_interval)
            begin
                $display("%0t: zero_interval expected %b actual %b",
                         $time, e.zero_interval, zi);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // level_a, level_b, now_ms[31:0], zero pad
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;   // position[31:0], speed[31:0]
    logic [1:0]  m_tuser;   // speed_valid, zero_interval
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    qps_board    board = new();
    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 76;
    logic        hold_req = 1'b0;
    int unsigned hold_left = 300;
    int unsigned sent_items;
    logic [31:0] clock_ms;

    quadrature_position_speed DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]);
            // long hold-off so results back up into the input side
            if (hold_req && hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #15_000_000;
        $display("FAIL quadrature_position_speed");
        $finish;
    end

    task automatic send_event(logic [1:0] act, logic la, logic lb, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {6'd0, now, lb, la};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_event(act, la, lb, now);
        sent_items++;
    endtask

    task automatic send_edge(bit up);
        logic a;
        logic b;
        logic [1:0] act;
        a = 1'($urandom_range(1));
        act = $urandom_range(1) ? ACT_EDGE_B : ACT_EDGE_A;
        // A counts up on equal levels, B on different levels
        if (act == ACT_EDGE_A)
            b = up ? a : ~a;
        else
            b = up ? ~a : a;
        send_event(act, a, b, $urandom);
    endtask

    task automatic send_run();
        int unsigned pick;
        int unsigned steps;
        bit up;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            steps = $urandom_range(40);
            up = 1'($urandom_range(1));
            repeat (steps) send_edge(up);
            if (pick < 8)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(6);
            send_event(ACT_SPEED, 1'($urandom_range(1)), 1'($urandom_range(1)), clock_ms);
        end
        else if (pick < 95)
            send_event(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       $urandom);
        else
            send_event(ACT_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_and_set_cpr(logic [15:0] value);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        apb_write(CPR_ADDR, {16'd0, value});
        board.set_cpr(value);
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] cpr_plan[5];
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= ACT_EDGE_A;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sent_items = 0;
        clock_ms = '0;
        cpr_plan[0] = 16'd1;
        cpr_plan[1] = 16'd65535;
        cpr_plan[2] = 16'd0;
        cpr_plan[3] = 16'($urandom_range(65535, 1));
        cpr_plan[4] = 16'($urandom_range(200, 2));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stored time is zero out of reset, so this is a zero interval
        send_event(ACT_SPEED, 1'b0, 1'b0, 32'd0);
        send_event(ACT_EDGE_A, 1'b0, 1'b0, 32'd0);
        send_event(ACT_EDGE_A, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_event(ACT_EDGE_A, 1'b0, 1'b1, 32'd0);
        send_event(ACT_EDGE_A, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_event(ACT_EDGE_B, 1'b0, 1'b1, 32'd0);
        send_event(ACT_EDGE_B, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_event(ACT_EDGE_B, 1'b0, 1'b0, 32'd0);
        send_event(ACT_EDGE_B, 1'b1, 1'b1, 32'hFFFF_FFFF);
        repeat (3) send_event(ACT_EDGE_A, 1'b1, 1'b1, 32'd0);
        send_event(ACT_SPEED, 1'b1, 1'b1, 32'd1);
        repeat (2) send_event(ACT_EDGE_B, 1'b1, 1'b1, 32'd0);
        send_event(ACT_SPEED, 1'b0, 1'b1, 32'hFFFF_FFFF);
        // time wraps past zero
        send_event(ACT_SPEED, 1'b1, 1'b0, 32'd4);
        send_event(ACT_EDGE_A, 1'b0, 1'b1, 32'd0);
        send_event(ACT_SPEED, 1'b0, 1'b0, 32'd4);
        send_event(ACT_CLEAR, 1'b1, 1'b1, 32'h5A5A_A5A5);
        send_event(ACT_EDGE_A, 1'b0, 1'b0, 32'd0);
        send_event(ACT_SPEED, 1'b1, 1'b1, 32'h8000_0000);
        send_event(ACT_CLEAR, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_event(ACT_SPEED, 1'b0, 1'b0, 32'h7FFF_FFFF);

        for (int p = 0; p < 5; p++)
        begin
            drain_and_set_cpr(cpr_plan[p]);
            clock_ms = $urandom;
            if (p == 0)
                hold_req <= 1'b1;
            if (p == 2)
            begin
                send_idle_pct = 76;
                recv_idle_pct <= 27;
            end
            if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            sent_items = 0;
            while (sent_items < 250)
                send_run();
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS quadrature_position_speed");
        else
            $display("FAIL quadrature_position_speed");
        $finish;
    end
endmodule
